@@ src/spq_pkg.sv @@
package spq_pkg;

    // Payload widths fixed by the channel fields
    localparam int DATA_W   = 32;
    localparam int COUNT_W  = 5;
    localparam int STATUS_W = 2;

    // Default number of cells in the chain
    localparam int CAPACITY_DEF = 16;

    typedef logic signed [DATA_W-1:0] data_t;

    // Operation codes carried on the action field
    localparam logic ACTION_PUSH = 1'b0;
    localparam logic ACTION_POP  = 1'b1;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    // Per-cycle command broadcast to every cell
    typedef struct packed {
        logic push;
        logic pop;
    } spq_ctrl_t;

endpackage

@@ src/spq_req_if.sv @@
interface spq_req_if
    import spq_pkg::*;
();
    logic  valid;
    logic  ready;
    logic  action;
    data_t value;

    modport source (output valid, output action, output value, input ready);
    modport sink   (input valid, input action, input value, output ready);
endinterface

@@ src/spq_rsp_if.sv @@
interface spq_rsp_if
    import spq_pkg::*;
();
    logic                valid;
    logic                ready;
    data_t               pop_value;
    logic [COUNT_W-1:0]  count;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output pop_value, output count, output status, input ready);
    modport sink   (input valid, input pop_value, input count, input status, output ready);
endinterface

@@ src/spq_cell.sv @@
module spq_cell
    import spq_pkg::*;
(
    input  logic      clk,
    input  spq_ctrl_t ctrl,
    input  data_t     value,
    input  logic      occ,
    input  logic      prev_keep,
    input  data_t     prev_entry,
    input  data_t     next_entry,
    output data_t     entry,
    output logic      keep
);

    data_t entry_reg;
    data_t entry_next;

    // Hold this entry on a push when it is occupied and not smaller than the new value
    assign keep  = occ && (entry_reg >= value);
    assign entry = entry_reg;

    // Select: hold, take the new value, take the lower neighbor, or take the upper one on pop
    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.push)
        begin
            if (!keep)
            begin
                if (prev_keep)
                    entry_next = value;
                else
                    entry_next = prev_entry;
            end
        end
        else if (ctrl.pop)
        begin
            entry_next = next_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

@@ src/sorted_priority_queue.sv @@
// Channel | Dir | Fields                       | Transfer
// --------+-----+------------------------------+---------------------
// req     | in  | action, value                | req.valid & req.ready
// rsp     | out | pop_value, count, status     | rsp.valid & rsp.ready
//
// One operation per cycle while req.ready is high; its result is captured in the output register.
// The rate is set by the compare and select in each cell of the chain.
// Reset clears the fill count and the output valid; cell contents stay undefined.
// req.ready drops only while a result waits and rsp.ready is low.
// Cells keep entries in descending order: cell 0 holds the largest entry.
module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    spq_req_if.sink   req,
    spq_rsp_if.source rsp
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int EXT_W = CNT_W + COUNT_W;

    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic                rsp_valid_reg;
    logic                rsp_valid_next;
    data_t               pop_value_reg;
    logic [COUNT_W-1:0]  count_out_reg;
    status_t             status_reg;

    logic                take;
    logic                is_pop;
    logic                full;
    logic                empty;
    spq_ctrl_t           ctrl;
    status_t             status_new;
    logic [EXT_W-1:0]    count_ext;

    data_t cell_entry [CAPACITY];
    logic  cell_keep  [CAPACITY];
    logic  prev_keep  [CAPACITY];
    data_t prev_entry [CAPACITY];
    data_t next_entry [CAPACITY];

    // Accept while the output register is empty or being drained
    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign take      = req.valid && req.ready;
    assign is_pop    = (req.action == ACTION_POP);
    assign full      = (count_reg == CNT_W'(CAPACITY));
    assign empty     = (count_reg == '0);

    // Drop pushes to a full store and pops of an empty one
    assign ctrl.push = take && !is_pop && !full;
    assign ctrl.pop  = take && is_pop && !empty;

    // Build the chain of cells with their neighbor links
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        if (i == 0)
        begin : g_first
            assign prev_keep[i]  = 1'b1;
            assign prev_entry[i] = req.value;
        end
        else
        begin : g_mid
            assign prev_keep[i]  = cell_keep[i-1];
            assign prev_entry[i] = cell_entry[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign next_entry[i] = cell_entry[i];
        end
        else
        begin : g_inner
            assign next_entry[i] = cell_entry[i+1];
        end

        spq_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .value      (req.value),
            .occ        (CNT_W'(i) < count_reg),
            .prev_keep  (prev_keep[i]),
            .prev_entry (prev_entry[i]),
            .next_entry (next_entry[i]),
            .entry      (cell_entry[i]),
            .keep       (cell_keep[i])
        );
    end

    // Advance the fill count
    always_comb
    begin
        count_next = count_reg;
        if (ctrl.push)
            count_next = count_reg + CNT_W'(1);
        else if (ctrl.pop)
            count_next = count_reg - CNT_W'(1);
    end

    // Classify the result of this transfer
    always_comb
    begin
        status_new = STATUS_OK;
        if (is_pop && empty)
            status_new = STATUS_EMPTY;
        else if (!is_pop && full)
            status_new = STATUS_FULL;
    end

    assign count_ext = EXT_W'(count_next);

    // Hold a result until it is taken
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (take)
            rsp_valid_next = 1'b1;
        else if (rsp.ready)
            rsp_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Capture the result payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            pop_value_reg <= ctrl.pop ? cell_entry[0] : '0;
            count_out_reg <= count_ext[COUNT_W-1:0];
            status_reg    <= status_new;
        end
    end

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.pop_value = pop_value_reg;
    assign rsp.count     = count_out_reg;
    assign rsp.status    = status_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("fill count exceeds capacity");

    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (take && !is_pop && full) |=>
            (rsp.status == STATUS_FULL && count_reg == $past(count_reg)))
        else $error("push to full store not dropped");

    a_pop_top: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.pop |=> (rsp.pop_value == $past(cell_entry[0])))
        else $error("pop did not return the top cell");

    for (genvar k = 0; k + 1 < CAPACITY; k++)
    begin : g_order_chk
        a_order: assert property (@(posedge clk) disable iff (!rst_n)
            (CNT_W'(k + 1) < count_reg) |-> (cell_entry[k] >= cell_entry[k+1]))
            else $error("cell chain out of order");
    end
`endif

endmodule

@@ test/tb_sorted_priority_queue.sv @@
module tb_sorted_priority_queue;
    import spq_pkg::*;

    localparam int CAPACITY = CAPACITY_DEF;
    localparam data_t VAL_MIN = 32'sh8000_0000;
    localparam data_t VAL_MAX = 32'sh7FFF_FFFF;

    typedef struct {
        data_t              pop_value;
        logic [COUNT_W-1:0] count;
        status_t            status;
    } queue_result_t;

    logic clk;
    logic rst_n;

    spq_req_if req_if ();
    spq_rsp_if rsp_if ();

    sorted_priority_queue #(
        .CAPACITY (CAPACITY)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    // Shadow copy of the sorted store, cell 0 holds the smallest entry
    data_t         shadow_cells [CAPACITY];
    int            shadow_fill;
    queue_result_t pending_results [$];

    int mismatch_count;
    int send_idle_pct;
    int recv_stall_pct;

    // Toggle the clock every half period
    always #10 clk = ~clk;

    // Print one mismatch line and count it
    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        mismatch_count++;
    endtask

    // Apply one operation to the shadow store and return its result
    function automatic queue_result_t predict_queue_op(input logic act, input data_t val);
        queue_result_t res;
        int            pos;
        int            i;
        res.pop_value = '0;
        res.status    = STATUS_OK;
        if (act == ACTION_POP)
        begin
            if (shadow_fill == 0)
            begin
                res.status = STATUS_EMPTY;
            end
            else
            begin
                shadow_fill--;
                res.pop_value = shadow_cells[shadow_fill];
            end
        end
        else if (shadow_fill >= CAPACITY)
        begin
            res.status = STATUS_FULL;
        end
        else
        begin
            // Insert ahead of the first entry not smaller than the new value
            pos = 0;
            while (pos < shadow_fill && shadow_cells[pos] < val)
                pos++;
            for (i = shadow_fill; i > pos; i--)
                shadow_cells[i] = shadow_cells[i-1];
            shadow_cells[pos] = val;
            shadow_fill++;
        end
        res.count = COUNT_W'(shadow_fill);
        return res;
    endfunction

    // Send one operation, with random idle cycles ahead of it
    task automatic send_op(input logic act, input data_t val);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid  <= 1'b1;
        req_if.action <= act;
        req_if.value  <= val;
        do
            @(posedge clk);
        while (!req_if.ready);
        pending_results.push_back(predict_queue_op(act, val));
    endtask

    // Hold until every expected result has arrived
    task automatic wait_results_done();
        req_if.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Compare one transfer on the result channel with the oldest expectation
    task automatic check_result();
        queue_result_t exp_res;
        if (pending_results.size() == 0)
        begin
            report_mismatch("result transfer with no operation outstanding");
        end
        else
        begin
            exp_res = pending_results.pop_front();
            if (rsp_if.pop_value !== exp_res.pop_value)
                report_mismatch($sformatf("pop_value %0d, expected %0d",
                                          rsp_if.pop_value, exp_res.pop_value));
            if (rsp_if.count !== exp_res.count)
                report_mismatch($sformatf("count %0d, expected %0d",
                                          rsp_if.count, exp_res.count));
            if (rsp_if.status !== exp_res.status)
                report_mismatch($sformatf("status %0d, expected %0d",
                                          rsp_if.status, exp_res.status));
        end
    endtask

    // Check each result transfer and stall the result channel at random
    always @(posedge clk)
    begin
        if (rst_n && rsp_if.valid && rsp_if.ready)
            check_result();
        rsp_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Pick a value: half random words, some near zero to force equal keys, some extremes
    function automatic data_t pick_value();
        int mode;
        mode = $urandom_range(0, 9);
        if (mode < 5)
            return data_t'($urandom);
        else if (mode < 8)
            return data_t'($urandom_range(0, 8)) - 4;
        else
        begin
            case ($urandom_range(0, 3))
                0:       return VAL_MIN;
                1:       return VAL_MAX;
                2:       return '0;
                default: return -1;
            endcase
        end
    endfunction

    // Run bursts of operations whose push ratio swings the store between empty and full
    task automatic run_random_ops(input int num_ops);
        int sent;
        int burst_len;
        int push_pct;
        int k;
        sent = 0;
        while (sent < num_ops)
        begin
            burst_len = $urandom_range(8, 40);
            case ($urandom_range(0, 3))
                0:       push_pct = 20;
                1:       push_pct = 50;
                2:       push_pct = 80;
                default: push_pct = 95;
            endcase
            for (k = 0; k < burst_len && sent < num_ops; k++)
            begin
                if ($urandom_range(0, 99) < push_pct)
                    send_op(ACTION_PUSH, pick_value());
                else
                    send_op(ACTION_POP, data_t'($urandom));
                sent++;
            end
        end
        wait_results_done();
    endtask

    // Empty pop, extremes, equal keys, fill to full, dropped pushes, pops
    task automatic test_directed_cases();
        int k;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_op(ACTION_POP, VAL_MAX);
        send_op(ACTION_PUSH, VAL_MAX);
        send_op(ACTION_PUSH, VAL_MIN);
        send_op(ACTION_PUSH, '0);
        send_op(ACTION_PUSH, -1);
        send_op(ACTION_PUSH, 1);
        for (k = 0; k < 4; k++)
            send_op(ACTION_PUSH, 7);
        for (k = 0; k < 4; k++)
            send_op(ACTION_PUSH, VAL_MIN);
        send_op(ACTION_PUSH, VAL_MAX);
        send_op(ACTION_PUSH, -7);
        send_op(ACTION_PUSH, 32'sh4000_0000);
        send_op(ACTION_PUSH, 32'shC000_0000);
        send_op(ACTION_PUSH, VAL_MIN);
        send_op(ACTION_PUSH, VAL_MAX);
        send_op(ACTION_POP, '0);
        send_op(ACTION_POP, '0);
        send_op(ACTION_POP, '0);
        wait_results_done();
    endtask

    task automatic test_random_no_idle();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_random_ops(320);
    endtask

    task automatic test_random_sender_idle();
        send_idle_pct  = 74;
        recv_stall_pct = 0;
        run_random_ops(320);
    endtask

    task automatic test_random_receiver_stall();
        send_idle_pct  = 0;
        recv_stall_pct = 74;
        run_random_ops(320);
    endtask

    task automatic test_random_both_idle();
        send_idle_pct  = 12;
        recv_stall_pct = 12;
        run_random_ops(320);
    endtask

    // Drive inputs, reset once, run the tests in turn, then report
    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        req_if.valid   = 1'b0;
        req_if.action  = ACTION_PUSH;
        req_if.value   = '0;
        rsp_if.ready   = 1'b0;
        shadow_fill    = 0;
        mismatch_count = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_random_no_idle();
        test_random_sender_idle();
        test_random_receiver_stall();
        test_random_both_idle();

        wait_results_done();
        repeat (5) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("tb_sorted_priority_queue: PASS");
        else
            $display("tb_sorted_priority_queue: FAIL");
        $finish;
    end

    // End the run if it hangs
    initial
    begin
        #20000000;
        $display("tb_sorted_priority_queue: FAIL");
        $finish;
    end

endmodule
